FILE: rtl/sipq_pkg.sv
// ----------------------------------------------------------------------------
// sipq_pkg
// Shared types and constants for the sorted-insert priority queue.
// ----------------------------------------------------------------------------
package sipq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int STATUS_W        = 2;
    localparam int OCC_W           = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Broadcast from the top level to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic pop;
        logic descending;
    } cell_ctrl_t;

endpackage

FILE: rtl/sipq_if.sv
// ----------------------------------------------------------------------------
// sipq_if
// Request, response and configuration channels of the priority queue.
// ----------------------------------------------------------------------------
interface sipq_req_if #(
    parameter int KEY_WIDTH = sipq_pkg::KEY_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [KEY_WIDTH-1:0] key;

    modport source (output valid, operation, key, input ready);
    modport sink   (input valid, operation, key, output ready);
endinterface

interface sipq_rsp_if #(
    parameter int KEY_WIDTH = sipq_pkg::KEY_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic [KEY_WIDTH-1:0]           popped_key;
    logic [sipq_pkg::STATUS_W-1:0]  status;
    logic [sipq_pkg::OCC_W-1:0]     occupancy;

    modport source (output valid, popped_key, status, occupancy, input ready);
    modport sink   (input valid, popped_key, status, occupancy, output ready);
endinterface

interface sipq_cfg_if;
    logic valid;
    logic ready;
    logic sort_descending;

    modport source (output valid, sort_descending, input ready);
    modport sink   (input valid, sort_descending, output ready);
endinterface

FILE: rtl/sipq_cell.sv
// ----------------------------------------------------------------------------
// sipq_cell
// One slot of the sorted chain: holds a key and its valid bit.
// ----------------------------------------------------------------------------
module sipq_cell #(
    parameter int KEY_WIDTH = sipq_pkg::KEY_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sipq_pkg::cell_ctrl_t ctrl,
    input  logic [KEY_WIDTH-1:0] new_key,
    input  logic [KEY_WIDTH-1:0] left_key,
    input  logic                 left_valid,
    input  logic [KEY_WIDTH-1:0] right_key,
    input  logic                 right_valid,
    input  logic                 found_in,
    output logic [KEY_WIDTH-1:0] key,
    output logic                 valid,
    output logic                 found_out
);

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;
    logic                 valid_reg;
    logic                 valid_next;
    logic                 ahead;

    // The stored key stays in front of the new key in the current order.
    assign ahead     = valid_reg &&
                       (ctrl.descending ? (key_reg > new_key) : (key_reg < new_key));
    assign found_out = found_in || !ahead;

    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctrl.ins)
        begin
            if (found_in)
            begin
                key_next   = left_key;
                valid_next = left_valid;
            end
            else if (!ahead)
            begin
                key_next   = new_key;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.pop)
        begin
            key_next   = right_key;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key   = key_reg;
    assign valid = valid_reg;

endmodule

FILE: rtl/sipq_chain.sv
// ----------------------------------------------------------------------------
// sipq_chain
// Row of cells; each cell takes from its left or right neighbour.
// ----------------------------------------------------------------------------
module sipq_chain #(
    parameter int QUEUE_DEPTH = sipq_pkg::QUEUE_DEPTH_DEF,
    parameter int KEY_WIDTH   = sipq_pkg::KEY_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sipq_pkg::cell_ctrl_t   ctrl,
    input  logic [KEY_WIDTH-1:0]   new_key,
    output logic [KEY_WIDTH-1:0]   front_key,
    output logic [QUEUE_DEPTH-1:0] valid_vec,
    output logic                   slot_found
);

    logic [KEY_WIDTH-1:0] key_w [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0] found_w;

    assign found_w[0] = 1'b0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic [KEY_WIDTH-1:0] left_key;
        logic                 left_valid;
        logic [KEY_WIDTH-1:0] right_key;
        logic                 right_valid;

        if (i == 0)
        begin : g_head
            assign left_key   = new_key;
            assign left_valid = 1'b0;
        end
        else
        begin : g_body_left
            assign left_key   = key_w[i-1];
            assign left_valid = valid_vec[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_key   = key_w[i];
            assign right_valid = 1'b0;
        end
        else
        begin : g_body_right
            assign right_key   = key_w[i+1];
            assign right_valid = valid_vec[i+1];
        end

        sipq_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .new_key     (new_key),
            .left_key    (left_key),
            .left_valid  (left_valid),
            .right_key   (right_key),
            .right_valid (right_valid),
            .found_in    (found_w[i]),
            .key         (key_w[i]),
            .valid       (valid_vec[i]),
            .found_out   (found_w[i+1])
        );
    end

    assign front_key  = key_w[0];
    assign slot_found = found_w[QUEUE_DEPTH];

endmodule

FILE: rtl/sorted_insert_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_top
// Bounded priority queue kept in sorted order in a chain of key cells.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake      Payload
//  req      in   valid / ready  operation, key
//  rsp      out  valid / ready  popped_key, status, occupancy
//  cfg      in   valid / ready  sort_descending (always ready)
//
//  Every request completes in the cycle in which it is accepted; one request
//  per cycle is sustained. The clock period is set by the found chain, which
//  ripples once through all QUEUE_DEPTH cells to locate the insert slot.
//  The response sits in an output register: req.ready is high while that
//  register is empty or is being drained, so a stalled rsp holds back req.
//  Reset empties the queue and selects ascending order; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue_top #(
    parameter int QUEUE_DEPTH = sipq_pkg::QUEUE_DEPTH_DEF,
    parameter int KEY_WIDTH   = sipq_pkg::KEY_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sipq_req_if.sink    req,
    sipq_rsp_if.source  rsp,
    sipq_cfg_if.sink    cfg
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Count of stored keys; it only feeds the occupancy field, the full and
    // empty decisions come straight from the cell valid bits.
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic                          desc_reg;

    logic                          rsp_valid_reg;
    logic [KEY_WIDTH-1:0]          popped_reg;
    logic [KEY_WIDTH-1:0]          popped_next;
    sipq_pkg::status_t             status_reg;
    sipq_pkg::status_t             status_next;
    logic [sipq_pkg::OCC_W-1:0]    occ_reg;

    logic                          fire;
    logic                          full;
    logic                          empty;
    sipq_pkg::cell_ctrl_t          ctrl;
    logic [KEY_WIDTH-1:0]          front_key;
    logic [QUEUE_DEPTH-1:0]        valid_vec;
    logic                          slot_found;

    // A request is taken whenever the response register can be refilled.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;

    // The order bit may be written at any time the block is idle.
    assign cfg.ready = 1'b1;

    // Cells fill from the front, so the last cell tells full, the first empty.
    assign full  = valid_vec[QUEUE_DEPTH-1];
    assign empty = !valid_vec[0];

    // A refused request (insert when full, pop when empty) leaves the cells
    // untouched.
    assign ctrl.ins        = fire && (req.operation == sipq_pkg::OP_INSERT) && !full;
    assign ctrl.pop        = fire && (req.operation == sipq_pkg::OP_POP) && !empty;
    assign ctrl.descending = desc_reg;

    sipq_chain #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .new_key    (req.key),
        .front_key  (front_key),
        .valid_vec  (valid_vec),
        .slot_found (slot_found)
    );

    always_comb
    begin
        count_next  = count_reg;
        popped_next = '0;
        status_next = sipq_pkg::ST_OK;
        if (req.operation == sipq_pkg::OP_INSERT)
        begin
            if (full)
            begin
                status_next = sipq_pkg::ST_FULL;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = sipq_pkg::ST_EMPTY;
            end
            else
            begin
                popped_next = front_key;
                count_next  = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            desc_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                desc_reg <= cfg.sort_descending;
            end
            if (fire)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload is loaded only with a new request.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            popped_reg <= popped_next;
            status_reg <= status_next;
            occ_reg    <= sipq_pkg::OCC_W'(count_next);
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.popped_key = popped_reg;
    assign rsp.status     = status_reg;
    assign rsp.occupancy  = occ_reg;

`ifndef SYNTH
    // The count register and the cell valid bits must describe the same fill.
    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("key count disagrees with cell valid bits");

    // Valid cells must form one unbroken run from the front.
    a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(valid_vec ^ (valid_vec >> 1)))
        else $error("cell valid bits are not packed at the front");

    // Any insert into a queue with room must find a slot in the chain.
    a_insert_finds_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins |-> slot_found)
        else $error("insert found no slot in the chain");

    // A pop on an empty queue is reported as such in the next response.
    a_empty_pop_status: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (req.operation == sipq_pkg::OP_POP) && empty) |=>
        (rsp.valid && (rsp.status == sipq_pkg::ST_EMPTY)))
        else $error("pop on empty queue not flagged");
`endif

endmodule

FILE: verif/tb_sorted_insert_priority_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_insert_priority_queue_top
// Self-checking testbench for the sorted-insert priority queue.
// ----------------------------------------------------------------------------
// A shadow copy of the queue is kept in the testbench. It is updated on every
// accepted request and on every accepted order write, and yields the response
// that the block owes for that request. Responses are compared in order with
// those predictions. Directed tests cover the empty queue, the key extremes,
// a full queue, a change of order with keys stored and one long hold-off
// that backs the block up. Random phases in both orders follow, with idle
// gaps on the request side and stalls on the response side.
// ----------------------------------------------------------------------------
module tb_sorted_insert_priority_queue_top;

    localparam int DEPTH           = sipq_pkg::QUEUE_DEPTH_DEF;
    localparam int KEY_W           = sipq_pkg::KEY_WIDTH_DEF;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int DRAIN_CYCLES    = 8;
    localparam int REPORT_LIMIT    = 100;
    // The limit lies well beyond the slowest correct run, at 12 ns a cycle.
    localparam longint LIMIT_NS    = 10_000_000;

    // One response as the block should return it.
    typedef struct packed {
        logic [KEY_W-1:0]           popped_key;
        sipq_pkg::status_t          status;
        logic [sipq_pkg::OCC_W-1:0] occupancy;
    } queue_result_t;

    logic clk;
    logic rst_n;

    sipq_req_if #(.KEY_WIDTH(KEY_W)) req ();
    sipq_rsp_if #(.KEY_WIDTH(KEY_W)) rsp ();
    sipq_cfg_if                      cfg ();

    sorted_insert_priority_queue_top #(
        .QUEUE_DEPTH (DEPTH),
        .KEY_WIDTH   (KEY_W)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // Shadow of the queue contents and of the order register.
    logic [KEY_W-1:0] shadow_keys [DEPTH];
    int               shadow_count;
    logic             shadow_descending;

    // Responses owed by the block, oldest first.
    queue_result_t    pending_results [$];

    int               error_count;

    // Stimulus knobs, changed from test to test.
    bit               src_gaps_on;
    bit               rsp_stalls_on;
    bit               hold_off_request;

    // ------------------------------------------------------------------------
    // Clock, and the run limit. A run that has not finished by the limit has
    // hung somewhere, which counts as a failure.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction. An insert scans from the front and stops at the first
    // stored key that is not ahead of the new key in the current order, so a
    // new key lands in front of keys equal to it. The stored keys are never
    // re-sorted when the order changes.
    // ------------------------------------------------------------------------
    function automatic queue_result_t predict_queue_op(input logic op,
                                                       input logic [KEY_W-1:0] key);
        queue_result_t res;
        int            slot;
        int            i;
        res.popped_key = '0;
        res.status     = sipq_pkg::ST_OK;
        if (op == sipq_pkg::OP_INSERT)
        begin
            if (shadow_count >= DEPTH)
            begin
                res.status = sipq_pkg::ST_FULL;
            end
            else
            begin
                slot = 0;
                while (slot < shadow_count &&
                       (shadow_descending ? (shadow_keys[slot] > key)
                                          : (shadow_keys[slot] < key)))
                    slot++;
                for (i = shadow_count; i > slot; i--)
                    shadow_keys[i] = shadow_keys[i - 1];
                shadow_keys[slot] = key;
                shadow_count++;
            end
        end
        else
        begin
            if (shadow_count == 0)
            begin
                res.status = sipq_pkg::ST_EMPTY;
            end
            else
            begin
                res.popped_key = shadow_keys[0];
                for (i = 1; i < shadow_count; i++)
                    shadow_keys[i - 1] = shadow_keys[i];
                shadow_count--;
            end
        end
        res.occupancy = sipq_pkg::OCC_W'(shadow_count);
        return res;
    endfunction

    // Prints one line per mismatch, up to a limit, and counts every one.
    task automatic report_mismatch(input string msg);
        if (error_count < REPORT_LIMIT)
            $display("[%0t] MISMATCH: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_response();
        queue_result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf(
                "response with no request outstanding (key %0h st %0d occ %0d)",
                rsp.popped_key, rsp.status, rsp.occupancy));
        end
        else
        begin
            want = pending_results.pop_front();
            if (rsp.popped_key !== want.popped_key)
                report_mismatch($sformatf("popped_key %0h, expected %0h",
                                          rsp.popped_key, want.popped_key));
            if (rsp.status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d",
                                          rsp.status, want.status));
            if (rsp.occupancy !== want.occupancy)
                report_mismatch($sformatf("occupancy %0d, expected %0d",
                                          rsp.occupancy, want.occupancy));
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor. All three channels are sampled at the rising edge, before the
    // edge's own updates land, so the sampled values are those the block saw.
    // A response accepted at an edge always belongs to a request accepted at
    // an earlier edge, so the order of the two checks below does not matter.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
                shadow_descending = cfg.sort_descending;
            if (rsp.valid && rsp.ready)
                check_response();
            if (req.valid && req.ready)
                pending_results.push_back(predict_queue_op(req.operation, req.key));
        end
    end

    // ------------------------------------------------------------------------
    // Response side. Ready drops at random for short stalls and now and then
    // for a longer one. A hold-off request from a test keeps ready low so that
    // the block backs up and refuses requests.
    initial
    begin : rsp_drain
        int stall_left;
        int roll;
        stall_left = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                stall_left       = HOLD_OFF_CYCLES;
            end
            else if (stall_left == 0 && rsp_stalls_on)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 4)
                    stall_left = $urandom_range(8, 30);
                else if (roll < 30)
                    stall_left = $urandom_range(1, 3);
            end
            if (stall_left > 0)
            begin
                rsp.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side helpers. Every task starts and ends at a rising edge.
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!src_gaps_on || roll < 55)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Full-range keys for the largest share, with enough small keys to give
    // many equal ones and a share of the extremes of the range.
    function automatic logic [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return $urandom();
        if (roll < 65)
            return $urandom_range(0, 7);
        if (roll < 80)
            return $urandom_range(0, 255);
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return {1'b1, {(KEY_W - 1){1'b0}}};
            default: return {1'b0, {(KEY_W - 1){1'b1}}};
        endcase
    endfunction

    // Offers one request after an optional gap and returns at the edge at
    // which it is accepted. Valid stays high, so a following call with no gap
    // issues back-to-back requests.
    task automatic send_request(input logic op, input logic [KEY_W-1:0] key);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.operation <= op;
        req.key       <= key;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    // Stops offering requests and waits until every owed response is in.
    // Every request produces a response, so an empty list means idle.
    task automatic wait_drain();
        req.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Writes the order register; only called with the block idle.
    task automatic write_order(input logic descending);
        cfg.valid           <= 1'b1;
        cfg.sort_descending <= descending;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // A pop straight after reset finds the queue empty.
    task automatic test_empty_pop();
        send_request(sipq_pkg::OP_POP, $urandom());
        wait_drain();
    endtask

    // The smallest and largest keys, the top bit alone, and an equal pair,
    // then pops to see the two smallest come out in ascending order.
    task automatic test_key_extremes();
        send_request(sipq_pkg::OP_INSERT, '1);
        send_request(sipq_pkg::OP_INSERT, '0);
        send_request(sipq_pkg::OP_INSERT, {1'b1, {(KEY_W - 1){1'b0}}});
        send_request(sipq_pkg::OP_INSERT, KEY_W'(1));
        send_request(sipq_pkg::OP_INSERT, KEY_W'(1));
        send_request(sipq_pkg::OP_POP, '1);
        send_request(sipq_pkg::OP_POP, '0);
        wait_drain();
    endtask

    // Fill the queue to the brim, then one insert too many.
    task automatic test_full_queue();
        int room;
        room = DEPTH - shadow_count;
        repeat (room) send_request(sipq_pkg::OP_INSERT, pick_key());
        send_request(sipq_pkg::OP_INSERT, $urandom());
        wait_drain();
    endtask

    // Switch to descending with the queue full of ascending keys. Later
    // inserts stop at the first stored key that is not larger than them.
    task automatic test_order_change();
        write_order(1'b1);
        send_request(sipq_pkg::OP_POP, $urandom());
        send_request(sipq_pkg::OP_POP, $urandom());
        send_request(sipq_pkg::OP_INSERT, KEY_W'(32'hFFFF_FFFE));
        send_request(sipq_pkg::OP_INSERT, KEY_W'(2));
        send_request(sipq_pkg::OP_POP, $urandom());
        wait_drain();
    endtask

    // The response side holds off for a long stretch while requests keep
    // coming, so the output register fills and the request side stalls.
    task automatic test_back_pressure();
        src_gaps_on      = 1'b0;
        hold_off_request = 1'b1;
        repeat (12)
            send_request(($urandom_range(0, 99) < 60) ? sipq_pkg::OP_INSERT
                                                      : sipq_pkg::OP_POP,
                         pick_key());
        wait_drain();
    endtask

    // A random phase: the insert share steers the queue towards full or
    // empty, so both ends are reached many times across the phases.
    task automatic test_random_traffic(input logic descending, input int count,
                                       input int insert_pct, input bit gaps, input bit stalls);
        write_order(descending);
        src_gaps_on   = gaps;
        rsp_stalls_on = stalls;
        repeat (count)
        begin
            if ($urandom_range(0, 99) < insert_pct)
                send_request(sipq_pkg::OP_INSERT, pick_key());
            else
                send_request(sipq_pkg::OP_POP, $urandom());
        end
        wait_drain();
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n               <= 1'b0;
        req.valid           <= 1'b0;
        req.operation       <= sipq_pkg::OP_INSERT;
        req.key             <= '0;
        cfg.valid           <= 1'b0;
        cfg.sort_descending <= 1'b0;
        shadow_count        = 0;
        shadow_descending   = 1'b0;
        error_count         = 0;
        src_gaps_on         = 1'b1;
        rsp_stalls_on       = 1'b1;
        hold_off_request    = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_pop();
        test_key_extremes();
        test_full_queue();
        test_order_change();
        test_back_pressure();

        // Order changes between phases happen with keys still stored.
        test_random_traffic(1'b0, 200, 65, 1'b1, 1'b1);
        test_random_traffic(1'b0, 200, 35, 1'b1, 1'b1);
        test_random_traffic(1'b1, 200, 70, 1'b1, 1'b0);
        test_random_traffic(1'b1, 150, 30, 1'b0, 1'b1);
        test_random_traffic(1'b0, 200, 55, 1'b0, 1'b0);
        test_random_traffic(1'b1, 200, 50, 1'b1, 1'b1);
        test_random_traffic(1'b0, 200, 75, 1'b1, 1'b1);
        test_random_traffic(1'b0, 100, 25, 1'b1, 1'b1);

        // Let any stray response show itself before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", pending_results.size()));

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
